/* rtl/prar_pkg.sv */
// ---------------------------------------------------------------------------
// prar_pkg - shared types and constants of the private address resolver
// Command word passed from front end to back end, codes, AES S-box.
// ---------------------------------------------------------------------------
package prar_pkg;

    // key table depth; status and count fields are sized for up to 16 keys
    localparam int MAX_KEYS = 16;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_KEYS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IRQ_MASK = 2'd2;

    localparam logic [1:0] ENABLE_ON = 2'h3;
    localparam logic [1:0] PRAND_TAG = 2'h1;

    localparam logic [1:0] OUT_LOADED   = 2'd0;
    localparam logic [1:0] OUT_RESOLVED = 2'd1;
    localparam logic [1:0] OUT_NOT_RES  = 2'd2;
    localparam logic [1:0] OUT_IGNORED  = 2'd3;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_RESOLVE = 2'd1;
    localparam logic [1:0] OP_IGNORE  = 2'd2;
    localparam logic [1:0] OP_NO_TAG  = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  slot;
        logic        half;
        logic [63:0] word;
        logic [23:0] prand;
        logic [23:0] hash;
        logic [4:0]  count;
        logic [2:0]  irq_mask;
    } cmd_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        gf_double = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

/* rtl/prar_front.sv */
// ---------------------------------------------------------------------------
// prar_front - input classification
// Turns an accepted word into a command for the back end queue.
// ---------------------------------------------------------------------------
module prar_front
    import prar_pkg::*;
(
    input  logic        action,
    input  logic [3:0]  key_slot,
    input  logic        key_half,
    input  logic [63:0] key_word,
    input  logic [47:0] device_address,
    input  logic [1:0]  enable,
    input  logic [4:0]  num_keys,
    input  logic [2:0]  irq_enable_mask,
    output cmd_t        cmd
);

    logic [4:0] count;

    // clamp key count to table size
    assign count = (int'(num_keys) > MAX_KEYS) ? 5'(MAX_KEYS) : num_keys;

    always_comb begin
        cmd.slot     = key_slot;
        cmd.half     = key_half;
        cmd.word     = key_word;
        cmd.prand    = device_address[47:24];
        cmd.hash     = device_address[23:0];
        cmd.count    = count;
        cmd.irq_mask = irq_enable_mask;
        if (!action) begin
            cmd.op = OP_LOAD;
        end else if (enable != ENABLE_ON) begin
            cmd.op = OP_IGNORE;
        end else if (device_address[47:46] != PRAND_TAG) begin
            cmd.op = OP_NO_TAG;
        end else begin
            cmd.op = OP_RESOLVE;
        end
    end

endmodule

/* rtl/prar_fifo.sv */
// ---------------------------------------------------------------------------
// prar_fifo - two-entry command queue
// Decouples the front end from the back end.
// ---------------------------------------------------------------------------
module prar_fifo
    import prar_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_data
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/prar_aes.sv */
// ---------------------------------------------------------------------------
// prar_aes - iterative AES-128 encryptor
// One round per cycle, round key expanded on the fly.
// ---------------------------------------------------------------------------
module prar_aes
    import prar_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [127:0] key,
    input  logic [127:0] pt,
    output logic         done,
    output logic [127:0] ct
);

    logic [127:0] state_reg, state_next;
    logic [127:0] rk_reg, rk_next;
    logic [7:0]   rcon_reg;
    logic [3:0]   round_reg;
    logic         busy_reg;
    logic         done_reg;

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] k [16];
    logic [7:0] nk [16];

    always_comb begin
        logic [7:0] a0, a1, a2, a3, all;
        for (int i = 0; i < 16; i++) begin
            s[i] = state_reg[127-8*i -: 8];
            k[i] = rk_reg[127-8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[r+4*c] = SBOX[s[r+4*((c+r)%4)]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0  = t[4*c];
            a1  = t[4*c+1];
            a2  = t[4*c+2];
            a3  = t[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            if (round_reg != 4'd10) begin
                m[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
                m[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
                m[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
                m[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
            end else begin
                m[4*c]   = a0;
                m[4*c+1] = a1;
                m[4*c+2] = a2;
                m[4*c+3] = a3;
            end
        end
        nk[0] = k[0] ^ SBOX[k[13]] ^ rcon_reg;
        nk[1] = k[1] ^ SBOX[k[14]];
        nk[2] = k[2] ^ SBOX[k[15]];
        nk[3] = k[3] ^ SBOX[k[12]];
        for (int i = 4; i < 16; i++) begin
            nk[i] = k[i] ^ nk[i-4];
        end
        for (int i = 0; i < 16; i++) begin
            rk_next[127-8*i -: 8]    = nk[i];
            state_next[127-8*i -: 8] = m[i] ^ nk[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (round_reg == 4'd10);
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (round_reg == 4'd10)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            state_reg <= pt ^ key;
            rk_reg    <= key;
            rcon_reg  <= 8'h01;
            round_reg <= 4'd1;
        end else if (busy_reg) begin
            state_reg <= state_next;
            rk_reg    <= rk_next;
            rcon_reg  <= gf_double(rcon_reg);
            round_reg <= round_reg + 4'd1;
        end
    end

    assign done = done_reg;
    assign ct   = state_reg;

endmodule

/* rtl/prar_back.sv */
// ---------------------------------------------------------------------------
// prar_back - command execution
// Key table, key walk sequencer and result register.
// ---------------------------------------------------------------------------
module prar_back
    import prar_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_outcome,
    output logic [3:0] m_status_index,
    output logic [4:0] m_keys_checked,
    output logic       m_irq
);

    localparam int KIDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int ADDR_W = KIDX_W + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD_HI = 3'd1;
    localparam logic [2:0] ST_RD_LO = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_AES   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]  state_reg, state_next;
    cmd_t        cmd_reg;
    logic [4:0]  k_reg, k_next;
    logic [4:0]  checked_reg, checked_next;
    logic        found_reg, found_next;
    logic [3:0]  matched_reg, matched_next;
    logic [63:0] key_hi_reg;

    logic [63:0] key_mem [2*MAX_KEYS];
    logic [63:0] rdata_reg;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic        wr_en;

    logic         aes_start;
    logic         aes_done;
    logic [127:0] aes_ct;
    logic         hit;

    logic        m_valid_reg;
    logic [1:0]  outcome_reg;
    logic [3:0]  status_reg;
    logic [4:0]  out_checked_reg;
    logic        irq_reg;
    logic        out_free;

    assign out_free  = !m_valid_reg || m_ready;
    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid;
    assign wr_en     = cmd_pop && (cmd.op == OP_LOAD) && (int'(cmd.slot) < MAX_KEYS);
    assign waddr     = {KIDX_W'(cmd.slot), cmd.half};
    assign raddr     = {KIDX_W'(k_reg), (state_reg == ST_RD_HI)};
    assign aes_start = (state_reg == ST_START);
    assign hit       = (aes_ct[23:0] == cmd_reg.hash);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[waddr] <= cmd.word;
        end
        rdata_reg <= key_mem[raddr];
    end

    prar_aes u_aes (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (aes_start),
        .key     ({key_hi_reg, rdata_reg}),
        .pt      ({104'd0, cmd_reg.prand}),
        .done    (aes_done),
        .ct      (aes_ct)
    );

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        checked_next = checked_reg;
        found_next   = found_reg;
        matched_next = matched_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    k_next       = 5'd0;
                    found_next   = 1'b0;
                    checked_next = ((cmd.op == OP_RESOLVE) || (cmd.op == OP_NO_TAG)) ?
                                   cmd.count : 5'd0;
                    if ((cmd.op == OP_RESOLVE) && (cmd.count != 5'd0)) begin
                        state_next = ST_RD_HI;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RD_HI: state_next = ST_RD_LO;
            ST_RD_LO: state_next = ST_START;
            ST_START: state_next = ST_AES;
            ST_AES: begin
                if (aes_done) begin
                    if (hit) begin
                        found_next   = 1'b1;
                        matched_next = k_reg[3:0];
                        checked_next = k_reg + 5'd1;
                        state_next   = ST_DONE;
                    end else if (k_reg + 5'd1 == cmd_reg.count) begin
                        state_next = ST_DONE;
                    end else begin
                        k_next     = k_reg + 5'd1;
                        state_next = ST_RD_HI;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            matched_reg <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            matched_reg <= matched_next;
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        k_reg       <= k_next;
        checked_reg <= checked_next;
        found_reg   <= found_next;
        if (cmd_pop) begin
            cmd_reg <= cmd;
        end
        if (state_reg == ST_RD_LO) begin
            key_hi_reg <= rdata_reg;
        end
        if ((state_reg == ST_DONE) && out_free) begin
            status_reg      <= matched_reg;
            out_checked_reg <= checked_reg;
            case (cmd_reg.op)
                OP_LOAD: begin
                    outcome_reg <= OUT_LOADED;
                    irq_reg     <= 1'b0;
                end
                OP_IGNORE: begin
                    outcome_reg <= OUT_IGNORED;
                    irq_reg     <= 1'b0;
                end
                default: begin
                    outcome_reg <= found_reg ? OUT_RESOLVED : OUT_NOT_RES;
                    irq_reg     <= cmd_reg.irq_mask[0] |
                                   (found_reg & cmd_reg.irq_mask[1]) |
                                   (!found_reg & cmd_reg.irq_mask[2]);
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_outcome      = outcome_reg;
    assign m_status_index = status_reg;
    assign m_keys_checked = out_checked_reg;
    assign m_irq          = irq_reg;

endmodule

/* rtl/private_address_resolver_core.sv */
// ---------------------------------------------------------------------------
// private_address_resolver_core - resolvable private address resolver
// Loads identity keys and resolves addresses against them with AES-128.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (s_*): one word is either a key half load (action 0) or a
//    resolve request (action 1). Accepted when s_valid and s_ready are high.
//  - Result channel (m_*): exactly one result word per input word, in order.
//  - Config port: cfg_we/cfg_index/cfg_data, write only, takes effect at once;
//    write only while the block is idle.
//  - Flow: a load or an ignored/untagged resolve goes from the queue through
//    the back end sequencer to the output register. A resolve walks up to 16
//    keys in turn, each with two key table reads, one start, ten AES rounds
//    and one compare. The key walk is set by the single round-per-cycle AES
//    engine and the key table's single read port.
//  - A two-word queue sits between the classifying front end and the
//    executing back end, so up to two further words are taken while one is
//    being worked on or its result waits.
//  - Reset clears config, the queue, the sequencer, the matched-key index and
//    the output valid flag. The key table is not cleared; slots must be loaded before use.
//  - When the receiver stalls, the result holds in the output register and
//    the back end waits; the queue fills and then s_ready drops.
// ---------------------------------------------------------------------------
module private_address_resolver_core
    import prar_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [3:0]            s_key_slot,
    input  logic                  s_key_half,
    input  logic [63:0]           s_key_word,
    input  logic [47:0]           s_device_address,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_outcome,
    output logic [3:0]            m_status_index,
    output logic [4:0]            m_keys_checked,
    output logic                  m_irq
);

    logic [1:0] enable_reg;
    logic [4:0] num_keys_reg;
    logic [2:0] irq_mask_reg;

    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;
    logic push;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 2'd0;
            num_keys_reg <= 5'd0;
            irq_mask_reg <= 3'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ENABLE:   enable_reg   <= cfg_data[1:0];
                REG_NUM_KEYS: num_keys_reg <= cfg_data;
                REG_IRQ_MASK: irq_mask_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign s_ready = !queue_full;
    assign push    = s_valid && s_ready;

    prar_front u_front (
        .action          (s_action),
        .key_slot        (s_key_slot),
        .key_half        (s_key_half),
        .key_word        (s_key_word),
        .device_address  (s_device_address),
        .enable          (enable_reg),
        .num_keys        (num_keys_reg),
        .irq_enable_mask (irq_mask_reg),
        .cmd             (front_cmd)
    );

    prar_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_valid),
        .pop_data  (queue_cmd)
    );

    prar_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (queue_valid),
        .cmd            (queue_cmd),
        .cmd_pop        (queue_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_outcome      (m_outcome),
        .m_status_index (m_status_index),
        .m_keys_checked (m_keys_checked),
        .m_irq          (m_irq)
    );

    // a resolved result names the key it stopped at
    a_resolved_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_outcome == OUT_RESOLVED)) |->
        ((m_keys_checked != 5'd0) && (m_status_index == 4'(m_keys_checked - 5'd1))))
        else $error("resolved status does not match keys checked");

    // loads and ignored resolves never count keys or raise irq
    a_quiet_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ((m_outcome == OUT_LOADED) || (m_outcome == OUT_IGNORED))) |->
        ((m_keys_checked == 5'd0) && !m_irq))
        else $error("load or ignored result carries key count or irq");

    // queue is only popped when it holds a word
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        queue_pop |-> queue_valid)
        else $error("command queue popped while empty");

endmodule
